### rtl/rpsf_pkg.sv
// Shared types, constants and sine table math for the polygon span fill block.
`default_nettype none
package rpsf_pkg;

	localparam int PHASE_STEPS_DEF  = 1024;
	localparam int MAX_VERTICES_DEF = 255;
	localparam int COORD_BITS_DEF   = 12;

	// Divider operand widths: span numerator magnitude and edge height.
	localparam int DIV_W = 25;
	localparam int DEN_W = 13;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q15_HALF    = 64'd16384;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic div_phase;
		logic div_interp;
		logic rom_rd;
		logic mul;
		logic vtx_wr;
		logic advance;
		logic x_wr;
		logic emit;
		logic emit_span;
		logic emit_last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic start_ok;
		logic flat;
		logic first_active;
		logic below;
		logic stop;
	} st_t;

	// Taylor sine to x^9, Q30
	function automatic logic [63:0] series_sin(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 72;
		t = Q30_ONE - ((x2 * t) >> 30) / 42;
		t = Q30_ONE - ((x2 * t) >> 30) / 20;
		t = Q30_ONE - ((x2 * t) >> 30) / 6;
		return (x * t) >> 30;
	endfunction

	// Taylor cosine to x^10, Q30
	function automatic logic [63:0] series_cos(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 90;
		t = Q30_ONE - ((x2 * t) >> 30) / 56;
		t = Q30_ONE - ((x2 * t) >> 30) / 30;
		t = Q30_ONE - ((x2 * t) >> 30) / 12;
		t = Q30_ONE - ((x2 * t) >> 30) / 2;
		return t;
	endfunction

	// Quarter-turn magnitude in Q15, folded at the octant
	function automatic logic [15:0] quarter(input logic [63:0] u, input logic want_sin);
		logic [63:0] th;
		logic [63:0] v;
		if (u <= (Q30_ONE >> 1)) begin
			th = (u * HALF_PI_Q30) >> 30;
			v = want_sin ? series_sin(th) : series_cos(th);
		end else begin
			th = ((Q30_ONE - u) * HALF_PI_Q30) >> 30;
			v = want_sin ? series_cos(th) : series_sin(th);
		end
		v = (v + Q15_HALF) >> 15;
		if (v > 64'd32767) v = 64'd32767;
		return v[15:0];
	endfunction

endpackage
`default_nettype wire

### rtl/regular_polygon_span_fill_top.sv
// Top level of the regular polygon scanline span fill engine.
//
// Usage: drive the item fields with start high; the item transfers on a
// rising edge where start is high and busy is low. func = 0 loads a new
// polygon (centre, corner count, radius, color); func = 1 asks for the
// next span. Every item gives exactly one result: done pulses high for one
// cycle with span_valid, row, x_left, x_right, span_color and last.
// A result cannot be held off; it must be taken in the cycle it shows.
// A rejected start and a span request while no polygon is active skip
// the computation. A valid start runs the bit-serial divider that computes the
// vertex phase, then table read, multiply and round. A span runs the divider
// for the edge interpolation (not on a flat edge), then repeats the vertex
// computation for each polygon corner passed on the step to the next row.
// One item is worked on at a time; busy stays high until its result shows.
// Reset clears the controller and the held polygon; no polygon is active.
`default_nettype none
module regular_polygon_span_fill_top #(
	parameter int PHASE_STEPS  = rpsf_pkg::PHASE_STEPS_DEF,
	parameter int MAX_VERTICES = rpsf_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = rpsf_pkg::COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               func,
	input  wire logic signed [11:0] mid_x,
	input  wire logic signed [11:0] mid_y,
	input  wire logic [7:0]         vertices,
	input  wire logic [9:0]         radius,
	input  wire logic [31:0]        color,
	output logic                    done,
	output logic                    span_valid,
	output logic signed [12:0]      row,
	output logic signed [12:0]      x_left,
	output logic signed [12:0]      x_right,
	output logic [31:0]             span_color,
	output logic                    last
);
	import rpsf_pkg::*;

	cmd_t cmd;
	st_t  st;

	rpsf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.busy  (busy),
		.cmd   (cmd),
		.st    (st)
	);

	rpsf_dpath #(
		.PHASE_STEPS (PHASE_STEPS),
		.MAX_VERTICES(MAX_VERTICES),
		.COORD_BITS  (COORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.mid_x     (mid_x),
		.mid_y     (mid_y),
		.vertices  (vertices),
		.radius    (radius),
		.color     (color),
		.done      (done),
		.span_valid(span_valid),
		.row       (row),
		.x_left    (x_left),
		.x_right   (x_right),
		.span_color(span_color),
		.last      (last)
	);
endmodule
`default_nettype wire

### rtl/rpsf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rpsf_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      go,
	input  wire logic [rpsf_pkg::DIV_W-1:0] num,
	input  wire logic [rpsf_pkg::DEN_W-1:0] den,
	output logic                           done,
	output logic [rpsf_pkg::DIV_W-1:0]      quo
);
	import rpsf_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;

	// Shift in next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### rtl/rpsf_dpath.sv
// Datapath: held polygon, edge registers, sine table, multipliers, divider, result registers.
`default_nettype none
module rpsf_dpath #(
	parameter int PHASE_STEPS  = rpsf_pkg::PHASE_STEPS_DEF,
	parameter int MAX_VERTICES = rpsf_pkg::MAX_VERTICES_DEF,
	parameter int COORD_BITS   = rpsf_pkg::COORD_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpsf_pkg::cmd_t     cmd,
	output rpsf_pkg::st_t           st,
	input  wire logic signed [11:0] mid_x,
	input  wire logic signed [11:0] mid_y,
	input  wire logic [7:0]         vertices,
	input  wire logic [9:0]         radius,
	input  wire logic [31:0]        color,
	output logic                    done,
	output logic                    span_valid,
	output logic signed [12:0]      row,
	output logic signed [12:0]      x_left,
	output logic signed [12:0]      x_right,
	output logic [31:0]             span_color,
	output logic                    last
);
	import rpsf_pkg::*;

	localparam int PB = $clog2(PHASE_STEPS);

	typedef logic signed [15:0] rom_t [PHASE_STEPS];

	// Quadrant-signed sine or cosine table, built at elaboration
	function automatic rom_t build_rom(input logic want_sin);
		rom_t        r;
		logic [63:0] f;
		logic [63:0] u;
		logic [1:0]  q;
		logic signed [15:0] a;
		logic signed [15:0] b;
		for (int p = 0; p < PHASE_STEPS; p++) begin
			f = (64'(p) << 32) / PHASE_STEPS;
			q = f[31:30];
			u = f & (Q30_ONE - 64'd1);
			a = $signed(quarter(u, 1'b1));
			b = $signed(quarter(u, 1'b0));
			unique case (q)
				2'd0: r[p] = want_sin ? a : b;
				2'd1: r[p] = want_sin ? b : -a;
				2'd2: r[p] = want_sin ? -a : -b;
				default: r[p] = want_sin ? -b : a;
			endcase
		end
		return r;
	endfunction

	localparam rom_t SIN_ROM = build_rom(1'b1);
	localparam rom_t COS_ROM = build_rom(1'b0);

	// C-style t / 32768 with truncation toward zero; callers add 16384 first
	function automatic logic signed [11:0] rnd15(input logic signed [27:0] t);
		logic [27:0] m;
		m = t[27] ? 28'(-t) : 28'(t);
		m = m >> 15;
		return t[27] ? -$signed(12'(m)) : $signed(12'(m));
	endfunction

	// Wrap to COORD_BITS+1 bit two's complement, extend into the field
	function automatic logic signed [12:0] wrap(input logic signed [13:0] v);
		logic [16:0] e;
		logic [16:0] o;
		e = 17'(v);
		for (int b = 0; b < 17; b++) begin
			o[b] = (b <= COORD_BITS) ? e[b] : e[COORD_BITS];
		end
		return $signed(o[12:0]);
	endfunction

	logic signed [11:0] hcx_q, hcy_q;
	logic [9:0]         hr_q;
	logic [7:0]         hv_q;
	logic [31:0]        hcol_q;
	logic signed [11:0] row_q, pvx_q, pvy_q, nvx_q, nvy_q;
	logic [8:0]         idx_q;
	logic signed [15:0] s_q, c_q;
	logic signed [26:0] ps_q, pc_q;
	logic               neg_q;
	logic               done_q, sv_q, last_q;
	logic signed [12:0] orow_q, oxl_q, oxr_q;
	logic [31:0]        ocol_q;
	logic signed [12:0] prow_q, pxl_q, pxr_q;

	logic               div_go, div_done;
	logic [DIV_W-1:0]   div_num, div_quo;
	logic [DEN_W-1:0]   div_den;
	logic signed [12:0] dx, dyy, dys;
	logic signed [25:0] inum;
	logic [PB-1:0]      phase;
	logic signed [25:0] qs;
	logic signed [12:0] xv;
	logic [7:0]         vclamp;

	// Divider operand select: vertex phase or edge interpolation
	always_comb begin
		dx   = 13'(nvx_q) - 13'(pvx_q);
		dyy  = 13'(row_q) - 13'(pvy_q);
		dys  = 13'(nvy_q) - 13'(pvy_q);
		inum = dx * dyy;
		if (cmd.div_phase) begin
			div_num = DIV_W'(idx_q) * DIV_W'(2 * PHASE_STEPS) + DIV_W'(hv_q);
			div_den = DEN_W'({hv_q, 1'b0});
		end else begin
			div_num = inum[25] ? DIV_W'(-inum) : DIV_W'(inum);
			div_den = dys[12] ? DEN_W'(-dys) : DEN_W'(dys);
		end
		div_go = cmd.div_phase | cmd.div_interp;
	end

	rpsf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Phase index, span half-width
	always_comb begin
		phase  = (div_quo == DIV_W'(PHASE_STEPS)) ? '0 : div_quo[PB-1:0];
		qs     = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		xv     = st.flat ? 13'(nvx_q) : 13'(pvx_q) + qs[12:0];
		vclamp = (vertices > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES) : vertices;
	end

	// Status to controller
	always_comb begin
		st.div_done     = div_done;
		st.start_ok     = (hv_q >= 8'd3) && (hr_q != 10'd0);
		st.flat         = (nvy_q == pvy_q);
		st.first_active = (row_q <= nvy_q) || (nvy_q > pvy_q);
		st.below        = (row_q > nvy_q);
		st.stop         = nvx_q[11] || (idx_q >= 9'(hv_q));
	end

	// Polygon and edge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcx_q <= '0; hcy_q <= '0; hr_q <= '0; hv_q <= '0; hcol_q <= '0;
			row_q <= '0; pvx_q <= '0; pvy_q <= '0; nvx_q <= '0; nvy_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.latch) begin
				hcx_q  <= mid_x;
				hcy_q  <= mid_y;
				hv_q   <= vclamp;
				hr_q   <= radius;
				hcol_q <= color;
				idx_q  <= 9'd1;
				pvx_q  <= '0;
				pvy_q  <= -$signed({2'b00, radius});
				row_q  <= -$signed({2'b00, radius});
			end
			if (cmd.advance) begin
				idx_q <= idx_q + 9'd1;
				pvx_q <= nvx_q;
				pvy_q <= nvy_q;
			end
			if (cmd.vtx_wr) begin
				nvx_q <= rnd15(28'(ps_q) + 28'sd16384);
				nvy_q <= -rnd15(28'(pc_q) + 28'sd16384);
			end
			if (cmd.x_wr) begin
				row_q <= row_q + 12'sd1;
			end
		end
	end

	// Table read, products, sign of quotient, span capture
	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			s_q <= SIN_ROM[phase];
			c_q <= COS_ROM[phase];
		end
		if (cmd.mul) begin
			ps_q <= $signed({1'b0, hr_q}) * s_q;
			pc_q <= $signed({1'b0, hr_q}) * c_q;
		end
		if (cmd.div_interp) begin
			neg_q <= inum[25] ^ dys[12];
		end
		if (cmd.x_wr) begin
			prow_q <= wrap(14'(hcy_q) + 14'(row_q));
			pxl_q  <= wrap(14'(hcx_q) - 14'(xv));
			pxr_q  <= wrap(14'(hcx_q) + 14'(xv));
		end
	end

	// Result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0; sv_q <= 1'b0; last_q <= 1'b0;
			orow_q <= '0; oxl_q <= '0; oxr_q <= '0; ocol_q <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.emit) begin
				sv_q   <= cmd.emit_span;
				last_q <= cmd.emit_last;
				orow_q <= cmd.emit_span ? prow_q : '0;
				oxl_q  <= cmd.emit_span ? pxl_q : '0;
				oxr_q  <= cmd.emit_span ? pxr_q : '0;
				ocol_q <= cmd.emit_span ? hcol_q : '0;
			end
		end
	end

	assign done       = done_q;
	assign span_valid = sv_q;
	assign row        = orow_q;
	assign x_left     = oxl_q;
	assign x_right    = oxr_q;
	assign span_color = ocol_q;
	assign last       = last_q;
endmodule
`default_nettype wire

### rtl/rpsf_ctrl.sv
// Controller: sequences start, vertex computation, span interpolation and edge advance.
`default_nettype none
module rpsf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          func,
	output logic               busy,
	output rpsf_pkg::cmd_t     cmd,
	input  wire rpsf_pkg::st_t st
);
	import rpsf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_VGO, S_VWAIT, S_VROM, S_VMUL, S_VWR,
		S_FIRST, S_SGO, S_SWAIT, S_XWR, S_ADV, S_EMIT
	} state_t;

	state_t state_q;
	logic   active_q;
	logic   ret_adv_q;
	logic   span_q;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.latch      = accept && !func;
		cmd.div_phase  = (state_q == S_VGO);
		cmd.div_interp = (state_q == S_SGO) && !st.flat;
		cmd.rom_rd     = (state_q == S_VROM);
		cmd.mul        = (state_q == S_VMUL);
		cmd.vtx_wr     = (state_q == S_VWR);
		cmd.advance    = (state_q == S_ADV) && st.below && !st.stop;
		cmd.x_wr       = (state_q == S_XWR);
		cmd.emit       = (state_q == S_EMIT);
		cmd.emit_span  = span_q;
		cmd.emit_last  = !active_q;
	end

	// State machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			active_q  <= 1'b0;
			ret_adv_q <= 1'b0;
			span_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!func) begin
							ret_adv_q <= 1'b0;
							state_q   <= S_CHK;
						end else if (active_q) begin
							state_q <= S_SGO;
						end else begin
							span_q  <= 1'b0;
							state_q <= S_EMIT;
						end
					end
				end
				S_CHK: begin
					if (st.start_ok) begin
						state_q <= S_VGO;
					end else begin
						active_q <= 1'b0;
						span_q   <= 1'b0;
						state_q  <= S_EMIT;
					end
				end
				S_VGO:   state_q <= S_VWAIT;
				S_VWAIT: if (st.div_done) state_q <= S_VROM;
				S_VROM:  state_q <= S_VMUL;
				S_VMUL:  state_q <= S_VWR;
				S_VWR:   state_q <= ret_adv_q ? S_ADV : S_FIRST;
				S_FIRST: begin
					active_q <= st.first_active;
					span_q   <= 1'b0;
					state_q  <= S_EMIT;
				end
				S_SGO:   state_q <= st.flat ? S_XWR : S_SWAIT;
				S_SWAIT: if (st.div_done) state_q <= S_XWR;
				S_XWR:   state_q <= S_ADV;
				S_ADV: begin
					span_q <= 1'b1;
					if (st.below) begin
						if (st.stop) begin
							active_q <= 1'b0;
							state_q  <= S_EMIT;
						end else begin
							ret_adv_q <= 1'b1;
							state_q   <= S_VGO;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/rpsf_checker.sv
// Port-level checker for the span fill engine, bound to the top level.
`default_nettype none
module rpsf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic               span_valid,
	input wire logic signed [12:0] row,
	input wire logic signed [12:0] x_left,
	input wire logic signed [12:0] x_right,
	input wire logic [31:0]        span_color
);
	// A result only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	// A transfer always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transfer did not raise busy");

	// Busy rises only after a transfer
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without transfer");

	// Results without a span carry zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !span_valid |-> row == 13'sd0 && x_left == 13'sd0 &&
		x_right == 13'sd0 && span_color == 32'd0) else $error("empty result not zero");

	// Never two results in a row
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");
endmodule

bind regular_polygon_span_fill_top rpsf_checker u_rpsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.span_valid(span_valid),
	.row       (row),
	.x_left    (x_left),
	.x_right   (x_right),
	.span_color(span_color)
);
`default_nettype wire
